/* src/assert_macros.svh */
// Assertion macros shared by the resampler RTL.
// Needs clk and rst in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BIR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("resampler assertion failed");
`define BIR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("resampler assertion failed");
`define BIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("resampler assertion failed");
`else
`define BIR_ASSERT(lbl, expr)
`define BIR_ASSERT_IMPL(lbl, ante, cons)
`define BIR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/bir_pkg.sv */
// Shared constants and types of the bilinear resampler.
// No dependencies; used by every module of the block.
package bir_pkg;

  localparam int MAX_SRC_WIDTH_DEF  = 256;
  localparam int MAX_SRC_HEIGHT_DEF = 256;
  localparam int NUM_CHANNELS_DEF   = 4;

  localparam int CFG_IW   = 4;
  localparam int CFG_DW   = 25;
  localparam int SIZE_W   = 9;
  localparam int SCALE_W  = 25;
  localparam int POS_W    = 10;
  localparam int CH_W     = 2;
  localparam int SAMP_W   = 8;
  localparam int FRAC_W   = 16;
  localparam int FIX_W    = 38;
  localparam int CELL_W   = FIX_W - FRAC_W;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int ROW_W    = SAMP_W + FRAC_W;
  localparam int ACC_W    = ROW_W + FRAC_W + 1;

  localparam logic [WGT_W-1:0] ONE_Q16  = WGT_W'(65536);
  localparam logic [FIX_W-1:0] HALF_Q16 = FIX_W'(32768);
  localparam logic [ACC_W-1:0] ROUND_Q32 = ACC_W'(64'h8000_0000);

  typedef enum logic [CFG_IW-1:0] {
    REG_SOURCE_WIDTH  = 4'd0,
    REG_SOURCE_HEIGHT = 4'd1,
    REG_SCALE_X       = 4'd2,
    REG_SCALE_Y       = 4'd3
  } cfg_reg_t;

  // Per-item control that rides along the pipeline.
  typedef struct packed {
    logic is_sample;
    logic flag;   // write ignored, or sample on a channel that does not exist
  } item_ctl_t;

endpackage

/* src/bir_coord.sv */
// Maps a destination position into source space, x and y in parallel.
// Depends on bir_pkg.
module bir_coord (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bir_pkg::POS_W-1:0]     pos_x,
  input  logic [bir_pkg::POS_W-1:0]     pos_y,
  input  logic [bir_pkg::SCALE_W-1:0]   scale_x,
  input  logic [bir_pkg::SCALE_W-1:0]   scale_y,
  output logic signed [bir_pkg::CELL_W-1:0] cell_x,
  output logic signed [bir_pkg::CELL_W-1:0] cell_y,
  output logic [bir_pkg::FRAC_W-1:0]    frac_x,
  output logic [bir_pkg::FRAC_W-1:0]    frac_y
);
  import bir_pkg::*;

  logic [FIX_W-1:0] fx;
  logic [FIX_W-1:0] fy;

  // Q.16 position minus one half; a negative value wraps to cell -1 with the
  // right fraction in the low bits.
  always_ff @(posedge clk) begin
    if (en) begin
      fx <= FIX_W'(pos_x * scale_x) + FIX_W'(scale_x >> 1) - HALF_Q16;
      fy <= FIX_W'(pos_y * scale_y) + FIX_W'(scale_y >> 1) - HALF_Q16;
    end
  end

  assign cell_x = $signed(fx[FIX_W-1:FRAC_W]);
  assign cell_y = $signed(fy[FIX_W-1:FRAC_W]);
  assign frac_x = fx[FRAC_W-1:0];
  assign frac_y = fy[FRAC_W-1:0];

endmodule

/* src/bir_store.sv */
// Frame store in four banks split by column and row parity, so the four
// neighbours of a sample come out in one read. Depends on bir_pkg.
module bir_store #(
  parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int NUM_CHANNELS   = bir_pkg::NUM_CHANNELS_DEF,
  parameter int XW             = $clog2(MAX_SRC_WIDTH),
  parameter int YW             = $clog2(MAX_SRC_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          item_valid,
  input  logic                          operation,
  input  logic [bir_pkg::POS_W-1:0]     pos_x,
  input  logic [bir_pkg::POS_W-1:0]     pos_y,
  input  logic [bir_pkg::CH_W-1:0]      channel,
  input  logic [bir_pkg::SAMP_W-1:0]    sample_in,
  input  logic signed [bir_pkg::CELL_W-1:0] cell_x,
  input  logic signed [bir_pkg::CELL_W-1:0] cell_y,
  input  logic [bir_pkg::FRAC_W-1:0]    frac_x,
  input  logic [bir_pkg::FRAC_W-1:0]    frac_y,
  input  logic [XW-1:0]                 width_m1,
  input  logic [YW-1:0]                 height_m1,
  output bir_pkg::item_ctl_t            ctl,
  output logic [bir_pkg::FRAC_W-1:0]    tx,
  output logic [bir_pkg::FRAC_W-1:0]    ty,
  output logic [bir_pkg::SAMP_W-1:0]    v00,
  output logic [bir_pkg::SAMP_W-1:0]    v10,
  output logic [bir_pkg::SAMP_W-1:0]    v01,
  output logic [bir_pkg::SAMP_W-1:0]    v11
);
  import bir_pkg::*;

  localparam int HXW   = (XW > 1) ? XW - 1 : 1;
  localparam int HYW   = (YW > 1) ? YW - 1 : 1;
  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW    = HYW + HXW + CW;
  localparam int DEPTH = 1 << AW;

  function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [CELL_W-1:0] c,
                                                   input logic [CELL_W-1:0] m);
    logic signed [CELL_W-1:0] ms;
    ms = $signed(m);
    if (c < 0) return '0;
    else if (c > ms) return m;
    else return c;
  endfunction

  logic [XW-1:0] cx0, cx1;
  logic [YW-1:0] cy0, cy1;
  logic          bad_write;
  logic          bad_chan;
  logic [AW-1:0] waddr;
  logic [1:0]    wbank;
  logic [AW-1:0] raddr [4];
  logic [SAMP_W-1:0] rdata [4];
  logic          px0, px1, py0, py1;

  always_comb begin
    cx0 = XW'(clamp_cell(cell_x, CELL_W'(width_m1)));
    cx1 = XW'(clamp_cell(cell_x + CELL_W'(1), CELL_W'(width_m1)));
    cy0 = YW'(clamp_cell(cell_y, CELL_W'(height_m1)));
    cy1 = YW'(clamp_cell(cell_y + CELL_W'(1), CELL_W'(height_m1)));
    bad_chan  = 32'(channel) >= NUM_CHANNELS;
    bad_write = (32'(pos_x) > 32'(width_m1)) || (32'(pos_y) > 32'(height_m1)) || bad_chan;
    waddr = {HYW'(pos_y >> 1), HXW'(pos_x >> 1), CW'(channel)};
    wbank = {pos_y[0], pos_x[0]};
  end

  // A write lands in the memory before any later item reads it, so reads never
  // need forwarding.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SAMP_W-1:0] bank_mem [DEPTH];
    logic [XW-1:0]     col;
    logic [YW-1:0]     row;
    logic              we;

    // At a clamped edge both neighbours are the same pixel; the other
    // parity bank is then read but not used.
    assign col   = (cx0[0] == b[0]) ? cx0 : cx1;
    assign row   = (cy0[0] == b[1]) ? cy0 : cy1;
    assign raddr[b] = {HYW'(row >> 1), HXW'(col >> 1), CW'(channel)};
    assign we = en && item_valid && !operation && !bad_write && (wbank == 2'(b));

    always_ff @(posedge clk) begin
      if (we) begin
        bank_mem[waddr] <= sample_in;
      end
      if (en) begin
        rdata[b] <= bank_mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.is_sample <= operation;
      ctl.flag      <= operation ? bad_chan : bad_write;
      tx  <= frac_x;
      ty  <= frac_y;
      px0 <= cx0[0];
      px1 <= cx1[0];
      py0 <= cy0[0];
      py1 <= cy1[0];
    end
  end

  assign v00 = rdata[{py0, px0}];
  assign v10 = rdata[{py0, px1}];
  assign v01 = rdata[{py1, px0}];
  assign v11 = rdata[{py1, px1}];

endmodule

/* src/bir_blend.sv */
// Horizontal then vertical weighting of the four neighbours, with rounding,
// into the output register. Depends on bir_pkg.
module bir_blend (
  input  logic                       clk,
  input  logic                       en_row,
  input  logic                       en_out,
  input  bir_pkg::item_ctl_t         ctl,
  input  logic [bir_pkg::FRAC_W-1:0] tx,
  input  logic [bir_pkg::FRAC_W-1:0] ty,
  input  logic [bir_pkg::SAMP_W-1:0] v00,
  input  logic [bir_pkg::SAMP_W-1:0] v10,
  input  logic [bir_pkg::SAMP_W-1:0] v01,
  input  logic [bir_pkg::SAMP_W-1:0] v11,
  output logic                       is_sample,
  output logic [bir_pkg::SAMP_W-1:0] sample_out,
  output logic                       out_of_range
);
  import bir_pkg::*;

  logic [WGT_W-1:0] inv_tx;
  logic [WGT_W-1:0] inv_ty;
  logic [ROW_W-1:0] top, bot;
  logic [FRAC_W-1:0] ty_r;
  item_ctl_t        ctl_r;
  logic [ACC_W-1:0] acc;

  assign inv_tx = ONE_Q16 - WGT_W'(tx);
  assign inv_ty = ONE_Q16 - WGT_W'(ty_r);

  always_ff @(posedge clk) begin
    if (en_row) begin
      top   <= ROW_W'(v00 * inv_tx + v10 * WGT_W'(tx));
      bot   <= ROW_W'(v01 * inv_tx + v11 * WGT_W'(tx));
      ty_r  <= ty;
      ctl_r <= ctl;
    end
  end

  // The weighted sum never exceeds 255 in Q.32, so no saturation is needed.
  assign acc = ACC_W'(top * inv_ty) + ACC_W'(bot * WGT_W'(ty_r)) + ROUND_Q32;

  always_ff @(posedge clk) begin
    if (en_out) begin
      is_sample    <= ctl_r.is_sample;
      sample_out   <= (ctl_r.is_sample && !ctl_r.flag) ? acc[ACC_W-2 -: SAMP_W] : '0;
      out_of_range <= !ctl_r.is_sample && ctl_r.flag;
    end
  end

endmodule

/* src/bilinear_image_resampler_unit.sv */
// Bilinear resampler: one item enters per clock while in_stall is low and
// passes the coordinate, store, blend and output stages; the four-bank frame
// store sets the rate with all four neighbours in one read, and the pipeline
// keeps moving behind a stalled output register until all four stages are full.
// Writes store one sample; sample requests return the interpolated value. The
// frame store has no reset and no clearing pass; read only what was written.
`include "assert_macros.svh"
module bilinear_image_resampler_unit #(
  parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int NUM_CHANNELS   = bir_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bir_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bir_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [bir_pkg::POS_W-1:0]   pos_x,
  input  logic [bir_pkg::POS_W-1:0]   pos_y,
  input  logic [bir_pkg::CH_W-1:0]    channel,
  input  logic [bir_pkg::SAMP_W-1:0]  sample_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_sample,
  output logic [bir_pkg::SAMP_W-1:0]  sample_out,
  output logic                        out_of_range
);
  import bir_pkg::*;

  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);

  logic [SIZE_W-1:0]  source_width, source_height;
  logic [SCALE_W-1:0] scale_x, scale_y;
  logic [XW-1:0]      width_m1;
  logic [YW-1:0]      height_m1;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  logic                 op1;
  logic [POS_W-1:0]     px1, py1;
  logic [CH_W-1:0]      ch1;
  logic [SAMP_W-1:0]    val1;
  logic signed [CELL_W-1:0] cell_x, cell_y;
  logic [FRAC_W-1:0]    frac_x, frac_y;

  item_ctl_t         ctl2;
  logic [FRAC_W-1:0] tx2, ty2;
  logic [SAMP_W-1:0] v00, v10, v01, v11;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(256);
      source_height <= SIZE_W'(256);
      scale_x       <= SCALE_W'(65536);
      scale_y       <= SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SIZE_W-1:0];
        REG_SCALE_X:       scale_x       <= cfg_data;
        REG_SCALE_Y:       scale_y       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective size minus one: zero acts as one, oversize saturates.
  always_comb begin
    if (source_width == '0) width_m1 = '0;
    else if (32'(source_width) > MAX_SRC_WIDTH) width_m1 = XW'(MAX_SRC_WIDTH - 1);
    else width_m1 = XW'(source_width - SIZE_W'(1));
    if (source_height == '0) height_m1 = '0;
    else if (32'(source_height) > MAX_SRC_HEIGHT) height_m1 = YW'(MAX_SRC_HEIGHT - 1);
    else height_m1 = YW'(source_height - SIZE_W'(1));
  end

  // Each stage moves when it is empty or the stage after it moves.
  assign adv4 = !v4 || !out_stall;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall  = !adv1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1  <= operation;
      px1  <= pos_x;
      py1  <= pos_y;
      ch1  <= channel;
      val1 <= sample_in;
    end
  end

  bir_coord u_coord (
    .clk     (clk),
    .en      (adv1),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .scale_x (scale_x),
    .scale_y (scale_y),
    .cell_x  (cell_x),
    .cell_y  (cell_y),
    .frac_x  (frac_x),
    .frac_y  (frac_y)
  );

  bir_store #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .NUM_CHANNELS   (NUM_CHANNELS),
    .XW             (XW),
    .YW             (YW)
  ) u_store (
    .clk        (clk),
    .en         (adv2),
    .item_valid (v1),
    .operation  (op1),
    .pos_x      (px1),
    .pos_y      (py1),
    .channel    (ch1),
    .sample_in  (val1),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .frac_x     (frac_x),
    .frac_y     (frac_y),
    .width_m1   (width_m1),
    .height_m1  (height_m1),
    .ctl        (ctl2),
    .tx         (tx2),
    .ty         (ty2),
    .v00        (v00),
    .v10        (v10),
    .v01        (v01),
    .v11        (v11)
  );

  bir_blend u_blend (
    .clk          (clk),
    .en_row       (adv3),
    .en_out       (adv4),
    .ctl          (ctl2),
    .tx           (tx2),
    .ty           (ty2),
    .v00          (v00),
    .v10          (v10),
    .v01          (v01),
    .v11          (v11),
    .is_sample    (is_sample),
    .sample_out   (sample_out),
    .out_of_range (out_of_range)
  );

  `BIR_ASSERT_IMPL(a_write_zero, out_valid && !is_sample, sample_out == '0)
  `BIR_ASSERT_IMPL(a_sample_no_flag, out_valid && is_sample, !out_of_range)
  `BIR_ASSERT_IMPL(a_stall_only_full, in_stall, v1 && v2 && v3 && v4 && out_stall)
  `BIR_ASSERT_NEXT(a_store_holds, v2 && !adv3, v2)

endmodule
